FILE: rtl/slcdl_pkg.sv
// ----------------------------------------------------------------------------
// slcdl_pkg
// Shared widths, command and register codes, and the controller/datapath
// interface types for the slewed circular delay line.
// ----------------------------------------------------------------------------
`default_nettype none

package slcdl_pkg;

  localparam int DEF_MAX_DEPTH   = 4096;
  localparam int DEF_SAMPLE_BITS = 32;

  localparam int CMD_W      = 2;
  localparam int CAP_W      = 13;
  localparam int DLY_W      = 12;
  localparam int PEEK_W     = 12;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CAP_RESET  = 4096;

  localparam logic [CMD_W-1:0] CMD_PROCESS = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 2'd1;

  typedef struct packed {
    logic item_load;  // word accepted: step delay, write/read store
    logic clr_write;  // zero one store entry, advance sweep address
    logic clr_done;   // last entry of a sweep
    logic snap;       // restart: delay takes the target at end of sweep
    logic res_load;   // result register takes the pending result
  } slcdl_ctl_t;

  typedef struct packed {
    logic sweep_last;
  } slcdl_stat_t;

endpackage

`default_nettype wire

FILE: rtl/slewed_circular_delay_line_core.sv
// ----------------------------------------------------------------------------
// slewed_circular_delay_line_core
// Circular-store audio delay line with a delay that slews one sample per
// process word toward the target, plus peek, clear and restart commands.
// ----------------------------------------------------------------------------
// For a process or peek word the store is written and read at the
// accepting edge, and the registered read data enters the output register
// once that register is free to take it. Clear and restart walk the whole
// store through its single write port, one entry per cycle. After reset the
// same zeroing sweep runs before the first word is taken; configuration
// writes are accepted during it. A new word is taken while the previous
// result still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slewed_circular_delay_line_core
  import slcdl_pkg::*;
#(
  parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic        [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic        [CMD_W-1:0]       cmd,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic        [PEEK_W-1:0]      peek_back,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [OUT_W-1:0]       sample_out,
  output logic             [DLY_W-1:0]       delay_now,
  output logic                               range_error
);

  slcdl_ctl_t  ctl;
  slcdl_stat_t stat;

  slcdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  slcdl_dpath #(
    .MAX_DEPTH   (MAX_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sample_in   (sample_in),
    .peek_back   (peek_back),
    .ctl         (ctl),
    .stat        (stat),
    .sample_out  (sample_out),
    .delay_now   (delay_now),
    .range_error (range_error)
  );

endmodule

`default_nettype wire

FILE: rtl/slcdl_ctrl.sv
// ----------------------------------------------------------------------------
// slcdl_ctrl
// Sequencer: store sweep after reset and on clear/restart, word acceptance
// and result hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slcdl_ctrl
  import slcdl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CMD_W-1:0] cmd,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire slcdl_stat_t      stat,
  output slcdl_ctl_t            ctl
);

  typedef enum logic [1:0] {ST_CLR, ST_IDLE, ST_RES} state_t;

  state_t state;
  logic   clr_item;
  logic   snap_pend;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    ctl           = '0;
    ctl.item_load = in_valid && (state == ST_IDLE);
    ctl.clr_write = (state == ST_CLR);
    ctl.clr_done  = (state == ST_CLR) && stat.sweep_last;
    ctl.snap      = (state == ST_CLR) && stat.sweep_last && snap_pend;
    ctl.res_load  = (state == ST_RES) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_item  <= 1'b0;
      snap_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          if (stat.sweep_last) begin
            state <= clr_item ? ST_RES : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            case (cmd) inside
              CMD_CLEAR, CMD_RESTART: begin
                state     <= ST_CLR;
                clr_item  <= 1'b1;
                snap_pend <= (cmd == CMD_RESTART);
              end
              default: begin
                state    <= ST_RES;
                clr_item <= 1'b0;
              end
            endcase
          end
        end
        ST_RES: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/slcdl_dpath.sv
// ----------------------------------------------------------------------------
// slcdl_dpath
// Sample store, write position, slewed delay, configuration registers,
// circular address arithmetic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slcdl_dpath
  import slcdl_pkg::*;
#(
  parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic        [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic        [CMD_W-1:0]       cmd,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in,
  input  wire logic        [PEEK_W-1:0]      peek_back,
  input  wire slcdl_ctl_t                    ctl,
  output slcdl_stat_t                        stat,
  output logic signed      [OUT_W-1:0]       sample_out,
  output logic             [DLY_W-1:0]       delay_now,
  output logic                               range_error
);

  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int PW = ((AW > CAP_W) ? AW : CAP_W) + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DEPTH - 1);
  localparam logic [PW-1:0] DEPTH_P   = PW'(MAX_DEPTH);
  localparam logic [CAP_W-1:0] CAP_INIT =
    CAP_W'((MAX_DEPTH < CAP_RESET) ? MAX_DEPTH : CAP_RESET);

  logic [SAMPLE_BITS-1:0] mem [MAX_DEPTH];

  logic [AW-1:0]          wp;
  logic [AW-1:0]          cnt;
  logic [CAP_W-1:0]       cap;
  logic [DLY_W-1:0]       tgt;
  logic [DLY_W-1:0]       cur;
  logic [DLY_W-1:0]       cur_next;
  logic [AW-1:0]          last_pos;
  logic [AW-1:0]          pos;
  logic [PW-1:0]          pos_p;
  logic [PW-1:0]          back_p;
  logic [PW-1:0]          cap_p;
  logic [PW-1:0]          behind_p;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          wp_inc;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic                   wr_en;
  logic                   is_proc;
  logic                   peek_err;
  logic [PW-1:0]          cap_wr_p;
  logic [SAMPLE_BITS-1:0] rdata;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic [CMD_W-1:0]       cmd_q;
  logic                   bypass_q;
  logic                   err_q;

  assign is_proc = (cmd == CMD_PROCESS);
  assign cap_p   = PW'(cap);

  always_comb begin
    if (cur < tgt) begin
      cur_next = cur + 1'b1;
    end else if (cur > tgt) begin
      cur_next = cur - 1'b1;
    end else begin
      cur_next = cur;
    end
  end

  assign last_pos = (wp == '0) ? AW'(cap - 1'b1) : (wp - 1'b1);
  assign pos      = is_proc ? wp : last_pos;
  assign pos_p    = PW'(pos);
  assign back_p   = is_proc ? PW'(cur_next) : PW'(peek_back);
  assign behind_p = (pos_p >= back_p) ? (pos_p - back_p) : (pos_p + cap_p - back_p);
  assign rd_addr  = behind_p[AW-1:0];
  assign peek_err = (PW'(peek_back) >= cap_p);
  assign wp_inc   = ((PW'(wp) + 1'b1) >= cap_p) ? '0 : (wp + 1'b1);

  assign wr_en   = ctl.clr_write || (ctl.item_load && is_proc);
  assign wr_addr = ctl.clr_write ? cnt : wp;
  assign wr_data = ctl.clr_write ? '0 : sample_in;

  assign stat.sweep_last = (cnt == LAST_ADDR);
  assign cap_wr_p        = PW'(cfg_data);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.item_load) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      cnt <= '0;
      cap <= CAP_INIT;
      tgt <= '0;
      cur <= '0;
    end else begin
      if (ctl.item_load && is_proc) begin
        cur <= cur_next;
        wp  <= wp_inc;
      end
      if (ctl.clr_write) begin
        cnt <= stat.sweep_last ? '0 : (cnt + 1'b1);
      end
      if (ctl.clr_done) begin
        wp <= '0;
      end
      if (ctl.snap) begin
        cur <= tgt;
      end
      if (cfg_write) begin
        if (cfg_index == REG_CAPACITY) begin
          if ((cap_wr_p != '0) && (cap_wr_p <= DEPTH_P)) begin
            cap <= cfg_data;
            if (PW'(tgt) >= cap_wr_p) begin
              tgt <= DLY_W'(cap_wr_p - 1'b1);
            end
            if (PW'(cur) >= cap_wr_p) begin
              cur <= DLY_W'(cap_wr_p - 1'b1);
            end
            if (PW'(wp) >= cap_wr_p) begin
              wp <= '0;
            end
          end
        end else if (cfg_index == REG_TARGET) begin
          if (PW'(cfg_data[DLY_W-1:0]) < cap_p) begin
            tgt <= cfg_data[DLY_W-1:0];
          end
        end
      end
    end
  end

  // word context held until the result register is loaded
  always_ff @(posedge clk) begin
    if (ctl.item_load) begin
      cmd_q    <= cmd;
      sample_q <= sample_in;
      bypass_q <= is_proc && (rd_addr == wp);
      err_q    <= peek_err;
    end
    if (ctl.res_load) begin
      delay_now   <= cur;
      range_error <= (cmd_q == CMD_PEEK) && err_q;
      case (cmd_q)
        CMD_PROCESS: sample_out <= OUT_W'(bypass_q ? sample_q : rdata);
        CMD_PEEK:    sample_out <= err_q ? '0 : OUT_W'(rdata);
        default:     sample_out <= '0;
      endcase
    end
  end

  a_wp_in_range: assert property (@(posedge clk) disable iff (rst)
    PW'(wp) < cap_p)
    else $error("write position beyond capacity");

  a_cur_in_range: assert property (@(posedge clk) disable iff (rst)
    PW'(cur) < cap_p)
    else $error("current delay beyond capacity");

  a_tgt_in_range: assert property (@(posedge clk) disable iff (rst)
    PW'(tgt) < cap_p)
    else $error("target delay beyond capacity");

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for slewed_circular_delay_line_core. A word-level
// model of the store, the write pointer and the slewing delay predicts every
// result word. Directed words cover sample and distance extremes, delay slew,
// capacity and target edge writes, clear and restart. Random phases then run
// under varying capacity and target settings. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
  import slcdl_pkg::*;

  localparam int DEPTH = DEF_MAX_DEPTH;
  localparam int unsigned LIMIT = 1_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED0 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVED1 = 2'd3;

  typedef struct packed {
    logic [OUT_W-1:0] sample_out;
    logic [DLY_W-1:0] delay_now;
    logic             range_error;
  } delay_word_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic        [CFG_IDX_W-1:0]   cfg_index = '0;
  logic        [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic        [CMD_W-1:0]       cmd = CMD_PROCESS;
  logic signed [31:0]            sample_in = '0;
  logic        [PEEK_W-1:0]      peek_back = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [OUT_W-1:0]       sample_out;
  logic        [DLY_W-1:0]       delay_now;
  logic                          range_error;

  // shadow state of the delay line
  logic [31:0]  dl_store [DEPTH];
  int unsigned  dl_wpos;
  int unsigned  dl_delay;
  int unsigned  dl_cap;
  int unsigned  dl_target;

  delay_word_t  expected_words[$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  bit           calm = 1'b0;

  slewed_circular_delay_line_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .sample_in   (sample_in),
    .peek_back   (peek_back),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .delay_now   (delay_now),
    .range_error (range_error)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 23);
  end

  function automatic void wipe_store();
    foreach (dl_store[k]) dl_store[k] = '0;
    dl_wpos = 0;
  endfunction

  function automatic int unsigned index_behind(int unsigned pos, int unsigned back);
    int unsigned r;
    r = (pos >= back) ? pos - back : pos + dl_cap - back;
    if (r >= DEPTH) r = 0;
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (idx == REG_CAPACITY) begin
      if (val != 0 && val <= DEPTH) begin
        dl_cap = val;
        if (dl_target >= dl_cap) dl_target = dl_cap - 1;
        if (dl_delay >= dl_cap) dl_delay = dl_cap - 1;
        if (dl_wpos >= dl_cap) dl_wpos = 0;
      end
    end else if (idx == REG_TARGET) begin
      if (val[DLY_W-1:0] < dl_cap) dl_target = val[DLY_W-1:0];
    end
  endfunction

  function automatic delay_word_t step_delay_line(logic [CMD_W-1:0] op, logic [31:0] smp,
                                                  logic [PEEK_W-1:0] back);
    delay_word_t w;
    int unsigned last;
    w = '0;
    case (op)
      CMD_PROCESS: begin
        if (dl_delay < dl_target) dl_delay++;
        else if (dl_delay > dl_target) dl_delay--;
        if (dl_wpos >= DEPTH) dl_wpos = 0;
        dl_store[dl_wpos] = smp;
        w.sample_out = dl_store[index_behind(dl_wpos, dl_delay)];
        dl_wpos++;
        if (dl_wpos >= dl_cap) dl_wpos = 0;
      end
      CMD_PEEK: begin
        if (back >= dl_cap) begin
          w.range_error = 1'b1;
        end else begin
          last = (dl_wpos == 0) ? dl_cap - 1 : dl_wpos - 1;
          w.sample_out = dl_store[index_behind(last, back)];
        end
      end
      CMD_CLEAR: begin
        wipe_store();
      end
      default: begin
        wipe_store();
        dl_delay = dl_target;
      end
    endcase
    w.delay_now = dl_delay[DLY_W-1:0];
    return w;
  endfunction

  function automatic void note_failure(string what, delay_word_t want, delay_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: exp out=%h dly=%0d err=%b, got out=%h dly=%0d err=%b", $realtime,
               what, want.sample_out, want.delay_now, want.range_error,
               got.sample_out, got.delay_now, got.range_error);
  endfunction

  always @(posedge clk) begin : check_words
    delay_word_t got;
    delay_word_t want;
    if (!rst && out_valid && out_ready) begin
      got.sample_out  = sample_out;
      got.delay_now   = delay_now;
      got.range_error = range_error;
      if (expected_words.size() == 0) begin
        note_failure("unexpected word", '0, got);
      end else begin
        want = expected_words.pop_front();
        if (got.sample_out !== want.sample_out)   note_failure("sample_out", want, got);
        if (got.delay_now !== want.delay_now)     note_failure("delay_now", want, got);
        if (got.range_error !== want.range_error) note_failure("range_error", want, got);
      end
    end
  end

  task automatic send_word(input logic [CMD_W-1:0] op, input logic [31:0] smp,
                           input logic [PEEK_W-1:0] back);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= op;
    sample_in <= smp;
    peek_back <= back;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_words.push_back(step_delay_line(op, smp, back));
  endtask

  task automatic settle(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    apply_reg(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 39))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55)
      send_word(CMD_PROCESS, pick_sample(), PEEK_W'($urandom_range(0, 4095)));
    else if (r < 85)
      send_word(CMD_PEEK, $urandom,
                PEEK_W'(($urandom_range(0, 3) != 0) ? $urandom_range(0, dl_cap - 1)
                                                    : $urandom_range(0, 4095)));
    else if (r < 96)
      send_word($urandom_range(0, 1) ? CMD_PROCESS : CMD_PEEK, $urandom,
                PEEK_W'($urandom_range(0, 4095)));
    else if (r < 98)
      send_word(CMD_CLEAR, $urandom, PEEK_W'($urandom_range(0, 4095)));
    else
      send_word(CMD_RESTART, $urandom, PEEK_W'($urandom_range(0, 4095)));
  endtask

  // reset values: capacity 4096, target 0, so each sample comes straight out
  task automatic test_defaults();
    send_word(CMD_PROCESS, 32'h7FFF_FFFF, 12'd0);
    send_word(CMD_PROCESS, 32'h8000_0000, 12'hFFF);
    send_word(CMD_PROCESS, 32'h0000_0000, 12'd0);
    send_word(CMD_PROCESS, 32'hFFFF_FFFF, 12'd0);
    send_word(CMD_PEEK, 32'h0, 12'd0);
    send_word(CMD_PEEK, 32'hFFFF_FFFF, 12'd4095);
  endtask

  task automatic test_slew();
    settle(4);
    write_reg(REG_TARGET, 13'd3);
    repeat (4) send_word(CMD_PROCESS, $urandom, 12'd0);
    settle(4);
    write_reg(REG_TARGET, 13'd0);
    send_word(CMD_PROCESS, $urandom, 12'd0);
  endtask

  task automatic test_capacity_edges();
    settle(4);
    write_reg(REG_CAPACITY, 13'd0);
    write_reg(REG_CAPACITY, 13'd4097);
    write_reg(REG_CAPACITY, 13'h1FFF);
    write_reg(REG_RESERVED0, 13'h1FFF);
    write_reg(REG_RESERVED1, 13'd1);
    write_reg(REG_TARGET, 13'd4095);
    write_reg(REG_CAPACITY, 13'd1);
    write_reg(REG_TARGET, 13'd1);
    send_word(CMD_PROCESS, 32'h1234_5678, 12'd0);
    send_word(CMD_PROCESS, 32'h8765_4321, 12'd0);
    send_word(CMD_PEEK, 32'h0, 12'd0);
    send_word(CMD_PEEK, 32'h0, 12'd1);
    send_word(CMD_PEEK, 32'h0, 12'd4095);
  endtask

  task automatic test_clear_restart();
    settle(4);
    write_reg(REG_CAPACITY, 13'd8);
    write_reg(REG_TARGET, 13'd5);
    send_word(CMD_PROCESS, 32'h0BAD_F00D, 12'd0);
    send_word(CMD_PROCESS, 32'h7000_0001, 12'd0);
    send_word(CMD_RESTART, 32'hFFFF_FFFF, 12'hFFF);
    send_word(CMD_PROCESS, 32'h4000_0000, 12'd0);
    send_word(CMD_PROCESS, 32'hC000_0000, 12'd0);
    send_word(CMD_PEEK, 32'h0, 12'd3);
    send_word(CMD_CLEAR, 32'hFFFF_FFFF, 12'hFFF);
    send_word(CMD_PEEK, 32'h0, 12'd0);
  endtask

  // back-to-back words, no stalls on either side
  task automatic test_burst();
    settle(4);
    write_reg(REG_CAPACITY, 13'd4096);
    write_reg(REG_TARGET, 13'd2);
    calm = 1'b1;
    repeat (60) begin
      if ($urandom_range(0, 3) != 0)
        send_word(CMD_PROCESS, pick_sample(), PEEK_W'($urandom_range(0, 4095)));
      else
        send_word(CMD_PEEK, $urandom, PEEK_W'($urandom_range(0, 63)));
    end
    settle(4);
    calm = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [CFG_DATA_W-1:0] cap_val;
    logic [CFG_DATA_W-1:0] tgt_val;
    for (int p = 0; p < 6; p++) begin
      settle(4);
      case (p)
        0:       cap_val = 13'd1;
        1:       cap_val = 13'd2;
        2:       cap_val = CFG_DATA_W'($urandom_range(3, 40));
        3:       cap_val = 13'd4096;
        4:       cap_val = CFG_DATA_W'($urandom_range(41, 4095));
        default: cap_val = CFG_DATA_W'($urandom_range(2, 300));
      endcase
      case ($urandom_range(0, 3))
        0:       tgt_val = 13'd0;
        1:       tgt_val = cap_val - 1'b1;
        2:       tgt_val = CFG_DATA_W'($urandom_range(0, cap_val - 1));
        default: tgt_val = CFG_DATA_W'($urandom_range(0, 8191));
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(REG_CAPACITY, cap_val);
        write_reg(REG_TARGET, tgt_val);
      end else begin
        write_reg(REG_TARGET, tgt_val);
        write_reg(REG_CAPACITY, cap_val);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_RESERVED0 : REG_RESERVED1,
                  CFG_DATA_W'($urandom_range(0, 8191)));
      repeat (78) send_random_word();
    end
  endtask

  initial begin
    dl_cap    = CAP_RESET;
    dl_target = 0;
    dl_delay  = 0;
    wipe_store();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_slew();
    test_capacity_edges();
    test_clear_restart();
    test_burst();
    test_random_phases();
    settle(20);
    if (expected_words.size() != 0) begin
      $display("%0d expected words never arrived", expected_words.size());
      mismatches += expected_words.size();
    end
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/slcdl_pkg.sv
rtl/slcdl_ctrl.sv
rtl/slcdl_dpath.sv
rtl/slewed_circular_delay_line_core.sv
test/tb.sv
